FILE: hdl/cie_pkg.sv
package cie_pkg;

    // input item codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_REF  = 2'd0;
    localparam t_mode MODE_CAND = 2'd1;
    localparam t_mode MODE_END  = 2'd2;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CONE_RADIUS = 1'b0;
    localparam t_cfg_idx CFG_ET_LIMIT    = 1'b1;

    localparam logic [15:0] CONE_RADIUS_RESET = 16'd1638;
    localparam logic [39:0] ET_LIMIT_RESET    = 40'd10000;
    localparam logic [39:0] SUM_MAX           = 40'hFF_FFFF_FFFF;

    // angle and log constants, Q.16 and Q4.12
    localparam int TAB_LEN = 24;
    localparam logic signed [19:0] PIH_Q16    = 20'sd102944;
    localparam logic [15:0]        LN2_Q16    = 16'd45426;
    localparam logic [16:0]        PI_Q12     = 17'd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

    localparam logic [15:0] ATAN_Q16 [TAB_LEN] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024, 16'd512, 16'd256, 16'd128, 16'd64, 16'd32,
        16'd16, 16'd8, 16'd4, 16'd2, 16'd1, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };
    localparam logic [15:0] LN1P_Q16 [TAB_LEN] = '{
        16'd26573, 16'd14624, 16'd7719, 16'd3973, 16'd2017, 16'd1016,
        16'd510, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16,
        16'd8, 16'd4, 16'd2, 16'd1, 16'd0, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    // one classified particle passed from front to back
    typedef struct packed {
        t_mode              mode;
        logic               flat;
        logic signed [15:0] eta;
        logic signed [15:0] phi;
        logic [30:0]        et;
    } t_item;

    localparam int QUEUE_DEPTH = 4;

endpackage

FILE: hdl/cie_front.sv
module cie_front #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cie_pkg::t_mode     i_mode,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [30:0]        i_energy,
    output logic               o_push,
    output cie_pkg::t_item     o_item,
    input  logic               i_full
);
    import cie_pkg::*;

    localparam logic [4:0] F_IDLE = 5'd0;
    localparam logic [4:0] F_M0   = 5'd1;
    localparam logic [4:0] F_M1   = 5'd2;
    localparam logic [4:0] F_M2   = 5'd3;
    localparam logic [4:0] F_M3   = 5'd4;
    localparam logic [4:0] F_SQ1  = 5'd5;
    localparam logic [4:0] F_CHK  = 5'd6;
    localparam logic [4:0] F_SQ2  = 5'd7;
    localparam logic [4:0] F_MUL  = 5'd8;
    localparam logic [4:0] F_DV0  = 5'd9;
    localparam logic [4:0] F_DIV  = 5'd10;
    localparam logic [4:0] F_LNN  = 5'd11;
    localparam logic [4:0] F_LNS  = 5'd12;
    localparam logic [4:0] F_LNE  = 5'd13;
    localparam logic [4:0] F_ETA  = 5'd14;
    localparam logic [4:0] F_PHI  = 5'd15;
    localparam logic [4:0] F_PHE  = 5'd16;
    localparam logic [4:0] F_PUSH = 5'd17;

    localparam logic [4:0] LN_LAST  = 5'(CORDIC_STEPS);
    localparam logic [4:0] ROT_LAST = 5'(CORDIC_STEPS - 1);

    logic [4:0]         r_state;
    logic [4:0]         r_cnt;
    t_mode              r_mode;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [30:0]        r_e;
    logic [63:0]        r_prod, r_pt2, r_pm2;
    logic [63:0]        r_sv, r_sres;
    logic [31:0]        r_pt, r_pm;
    logic [31:0]        r_rem;
    logic [30:0]        r_dvd, r_quo;
    logic [32:0]        r_lv;
    logic [5:0]         r_lk;
    logic [31:0]        r_ly;
    logic [16:0]        r_lacc;
    logic               r_lsel;
    logic [21:0]        r_lna, r_lnb;
    logic signed [43:0] r_cx, r_cy;
    logic signed [19:0] r_cz;
    t_item              r_item;

    // magnitudes of the momentum components
    logic [31:0] w_ax, w_ay, w_az;
    assign w_ax = r_px[31] ? 32'(-r_px) : 32'(r_px);
    assign w_ay = r_py[31] ? 32'(-r_py) : 32'(r_py);
    assign w_az = r_pz[31] ? 32'(-r_pz) : 32'(r_pz);

    // shared 32x32 multiplier
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    always_comb begin
        case (r_state)
            F_M0: begin
                w_ma = w_ax;
                w_mb = w_ax;
            end
            F_M1: begin
                w_ma = w_ay;
                w_mb = w_ay;
            end
            F_M2: begin
                w_ma = w_az;
                w_mb = w_az;
            end
            default: begin
                w_ma = {1'b0, r_e};
                w_mb = r_pt;
            end
        endcase
    end
    assign w_mp = w_ma * w_mb;

    // square root, one result bit per cycle
    logic [63:0] w_sbit, w_strial;
    logic        w_sge;
    assign w_sbit   = 64'd1 << (6'd62 - {r_cnt, 1'b0});
    assign w_strial = r_sres + w_sbit;
    assign w_sge    = r_sv >= w_strial;

    // restoring divider, one quotient bit per cycle
    logic [32:0] w_dt, w_dsub;
    logic        w_dge;
    assign w_dt   = {r_rem, r_dvd[30]};
    assign w_dge  = w_dt >= {1'b0, r_pm};
    assign w_dsub = w_dt - {1'b0, r_pm};

    // log shift-and-add step
    logic [31:0] w_lt;
    logic        w_lle;
    logic [21:0] w_lres;
    assign w_lt   = r_ly + (r_ly >> r_cnt);
    assign w_lle  = w_lt <= {1'b0, r_lv[32:2]};
    assign w_lres = 22'(r_lk) * 22'(LN2_Q16) + 22'(r_lacc);

    // eta from the two logs
    logic signed [23:0] w_eq, w_eqc;
    logic [23:0]        w_eqr;
    logic [14:0]        w_mag;
    logic signed [15:0] w_eta;
    assign w_eq  = $signed({2'b0, r_lna}) - $signed({2'b0, r_lnb});
    assign w_eqc = w_eq[23] ? 24'sd0 : w_eq;
    assign w_eqr = (24'(w_eqc) + 24'd8) >> 4;
    assign w_mag = (w_eqr > 24'd32767) ? 15'h7FFF : w_eqr[14:0];
    assign w_eta = r_pz[31] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    // cordic rotation step and angle rounding
    logic signed [43:0] w_x0, w_y0, w_dx, w_dy;
    logic signed [19:0] w_zr;
    assign w_x0 = {{4{r_px[31]}}, r_px, 8'b0};
    assign w_y0 = {{4{r_py[31]}}, r_py, 8'b0};
    assign w_dx = r_cy >>> r_cnt;
    assign w_dy = r_cx >>> r_cnt;
    assign w_zr = r_cz + 20'sd8;

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_item  = r_item;

    // analysis sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_px   <= i_px;
                        r_py   <= i_py;
                        r_pz   <= i_pz;
                        r_e    <= i_energy;
                        case (i_mode)
                            MODE_REF, MODE_CAND: r_state <= F_M0;
                            MODE_END: begin
                                r_item.mode <= MODE_END;
                                r_item.flat <= 1'b0;
                                r_item.eta  <= '0;
                                r_item.phi  <= '0;
                                r_item.et   <= '0;
                                r_state     <= F_PUSH;
                            end
                            default: r_state <= F_IDLE;
                        endcase
                    end
                end
                F_M0: begin
                    r_prod  <= w_mp;
                    r_state <= F_M1;
                end
                F_M1: begin
                    r_pt2   <= r_prod;
                    r_prod  <= w_mp;
                    r_state <= F_M2;
                end
                F_M2: begin
                    r_pt2   <= r_pt2 + r_prod;
                    r_prod  <= w_mp;
                    r_state <= F_M3;
                end
                F_M3: begin
                    r_pm2   <= r_pt2 + r_prod;
                    r_sv    <= r_pt2;
                    r_sres  <= '0;
                    r_cnt   <= '0;
                    r_state <= F_SQ1;
                end
                F_SQ1, F_SQ2: begin
                    if (w_sge) begin
                        r_sv   <= r_sv - w_strial;
                        r_sres <= (r_sres >> 1) + w_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= (r_state == F_SQ1) ? F_CHK : F_MUL;
                    end
                end
                F_CHK: begin
                    r_pt <= r_sres[31:0];
                    if (r_sres == '0) begin
                        // no transverse momentum: outside every cone
                        r_item.mode <= r_mode;
                        r_item.flat <= 1'b1;
                        r_item.eta  <= '0;
                        r_item.phi  <= '0;
                        r_item.et   <= '0;
                        r_state     <= F_PUSH;
                    end else begin
                        r_sv    <= r_pm2;
                        r_sres  <= '0;
                        r_cnt   <= '0;
                        r_state <= F_SQ2;
                    end
                end
                F_MUL: begin
                    r_pm    <= r_sres[31:0];
                    r_state <= F_DV0;
                end
                F_DV0: begin
                    r_prod  <= w_mp;
                    r_state <= F_DIV;
                    r_cnt   <= '0;
                    r_rem   <= w_mp[62:31];
                    r_dvd   <= w_mp[30:0];
                end
                F_DIV: begin
                    r_rem <= w_dge ? w_dsub[31:0] : w_dt[31:0];
                    r_quo <= {r_quo[29:0], w_dge};
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd30) begin
                        r_lv    <= {1'b0, r_pm} + {1'b0, w_az};
                        r_lk    <= 6'd32;
                        r_lsel  <= 1'b0;
                        r_state <= F_LNN;
                    end
                end
                F_LNN: begin
                    if (r_lv[32]) begin
                        r_ly    <= 32'h4000_0000;
                        r_lacc  <= '0;
                        r_cnt   <= 5'd1;
                        r_state <= F_LNS;
                    end else begin
                        r_lv <= r_lv << 1;
                        r_lk <= r_lk - 6'd1;
                    end
                end
                F_LNS: begin
                    if (w_lle) begin
                        r_ly   <= w_lt;
                        r_lacc <= r_lacc + 17'(LN1P_Q16[5'(r_cnt - 5'd1)]);
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == LN_LAST) begin
                        r_state <= F_LNE;
                    end
                end
                F_LNE: begin
                    if (!r_lsel) begin
                        r_lna   <= w_lres;
                        r_lsel  <= 1'b1;
                        r_lv    <= {1'b0, r_pt};
                        r_lk    <= 6'd32;
                        r_state <= F_LNN;
                    end else begin
                        r_lnb   <= w_lres;
                        r_state <= F_ETA;
                    end
                end
                F_ETA: begin
                    r_item.mode <= r_mode;
                    r_item.flat <= 1'b0;
                    r_item.eta  <= w_eta;
                    r_item.et   <= r_quo;
                    r_cnt       <= '0;
                    // quadrant pre-rotation for negative x
                    if (w_x0 < 0) begin
                        if (w_y0 >= 0) begin
                            r_cx <= w_y0;
                            r_cy <= -w_x0;
                            r_cz <= PIH_Q16;
                        end else begin
                            r_cx <= -w_y0;
                            r_cy <= w_x0;
                            r_cz <= -PIH_Q16;
                        end
                    end else begin
                        r_cx <= w_x0;
                        r_cy <= w_y0;
                        r_cz <= '0;
                    end
                    r_state <= F_PHI;
                end
                F_PHI: begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + $signed({4'b0, ATAN_Q16[r_cnt]});
                    end else begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - $signed({4'b0, ATAN_Q16[r_cnt]});
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == ROT_LAST) begin
                        r_state <= F_PHE;
                    end
                end
                F_PHE: begin
                    r_item.phi <= 16'(w_zr >>> 4);
                    r_state    <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/cie_queue.sv
module cie_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cie_pkg::t_item i_data,
    output logic           o_full,
    input  logic           i_pop,
    output cie_pkg::t_item o_data,
    output logic           o_empty
);
    import cie_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/cie_back.sv
module cie_back #(
    parameter int MAX_REFS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    output logic           o_pop,
    input  cie_pkg::t_item i_item,
    input  logic [15:0]    i_cone_radius,
    input  logic [39:0]    i_et_limit,
    output logic           o_valid,
    input  logic           i_stall,
    output logic           o_isolated,
    output logic           o_ref_overflow
);
    import cie_pkg::*;

    localparam int IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW = $clog2(MAX_REFS + 1);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD   = 4'd1;
    localparam logic [3:0] B_DIF  = 4'd2;
    localparam logic [3:0] B_SQE  = 4'd3;
    localparam logic [3:0] B_SQP  = 4'd4;
    localparam logic [3:0] B_UPD  = 4'd5;
    localparam logic [3:0] B_ERD  = 4'd6;
    localparam logic [3:0] B_ECMP = 4'd7;
    localparam logic [3:0] B_EMIT = 4'd8;

    logic signed [15:0] mem_eta  [MAX_REFS];
    logic signed [15:0] mem_phi  [MAX_REFS];
    logic               mem_flat [MAX_REFS];
    logic [39:0]        mem_sum  [MAX_REFS];

    logic [3:0]         r_state;
    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic [IW-1:0]      r_j;
    t_item              r_cur;
    logic               r_iso;
    logic               r_ov, r_oiso, r_oovf;
    logic [31:0]        r_rad_sq;
    logic signed [15:0] r_rd_eta, r_rd_phi;
    logic               r_rd_flat;
    logic [39:0]        r_rd_sum;
    logic [15:0]        r_adeta, r_adphi;
    logic [31:0]        r_sqe;
    logic [32:0]        r_q;

    // radius squared follows the register
    logic [31:0] w_rsq;
    assign w_rsq = i_cone_radius * i_cone_radius;

    // distance terms
    logic signed [16:0] w_deta, w_dp;
    logic [16:0]        w_dpa;
    logic signed [17:0] w_fold;
    logic [15:0]        w_adeta, w_adphi;
    assign w_deta  = $signed({r_rd_eta[15], r_rd_eta}) - $signed({r_cur.eta[15], r_cur.eta});
    assign w_dp    = $signed({r_rd_phi[15], r_rd_phi}) - $signed({r_cur.phi[15], r_cur.phi});
    assign w_adeta = w_deta[16] ? 16'(-w_deta) : 16'(w_deta);
    assign w_dpa   = w_dp[16] ? 17'(-w_dp) : 17'(w_dp);
    assign w_fold  = TWO_PI_Q12 - $signed({1'b0, w_dpa});
    always_comb begin
        if (w_dpa > PI_Q12) begin
            w_adphi = w_fold[17] ? 16'(-w_fold) : 16'(w_fold);
        end else begin
            w_adphi = w_dpa[15:0];
        end
    end

    // shared squarer
    logic [15:0] w_mop;
    logic [31:0] w_sq;
    assign w_mop = (r_state == B_SQE) ? r_adeta : r_adphi;
    assign w_sq  = w_mop * w_mop;

    // saturating cone sum
    logic [40:0] w_sum;
    logic [39:0] w_sum_sat;
    assign w_sum     = {1'b0, r_rd_sum} + 41'(r_cur.et);
    assign w_sum_sat = w_sum[40] ? SUM_MAX : w_sum[39:0];

    logic w_last;
    assign w_last = ((CW'(r_j) + CW'(1)) == r_count);

    // result register takes a new result when empty or being taken
    logic w_emit;
    assign w_emit = (r_state == B_EMIT) && (!r_ov || !i_stall);

    // store writes: new reference or cone update
    logic          w_load, w_upd;
    logic [IW-1:0] w_widx;
    assign o_pop  = (r_state == B_IDLE) && !i_empty;
    assign w_load = o_pop && (i_item.mode == MODE_REF) && (r_count < CW'(MAX_REFS));
    assign w_upd  = (r_state == B_UPD) && (r_q < {1'b0, r_rad_sq});
    assign w_widx = r_count[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_eta[w_widx]  <= i_item.eta;
            mem_phi[w_widx]  <= i_item.phi;
            mem_flat[w_widx] <= i_item.flat;
            mem_sum[w_widx]  <= '0;
        end else if (w_upd) begin
            mem_sum[r_j] <= w_sum_sat;
        end
        r_rd_eta  <= mem_eta[r_j];
        r_rd_phi  <= mem_phi[r_j];
        r_rd_flat <= mem_flat[r_j];
        r_rd_sum  <= mem_sum[r_j];
    end

    // walk sequencer
    always_ff @(posedge i_clk) begin
        r_rad_sq <= w_rsq;
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output valid: set on emit, cleared once taken
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_cur <= i_item;
                        r_j   <= '0;
                        case (i_item.mode)
                            MODE_REF: begin
                                if (w_load) begin
                                    r_count <= r_count + CW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            MODE_CAND: begin
                                if (!i_item.flat && (r_count != '0)) begin
                                    r_state <= B_RD;
                                end
                            end
                            MODE_END: begin
                                r_iso   <= 1'b1;
                                r_state <= (r_count == '0) ? B_EMIT : B_ERD;
                            end
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                B_RD: r_state <= B_DIF;
                B_DIF: begin
                    if (r_rd_flat) begin
                        if (w_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_j     <= r_j + IW'(1);
                            r_state <= B_RD;
                        end
                    end else begin
                        r_adeta <= w_adeta;
                        r_adphi <= w_adphi;
                        r_state <= B_SQE;
                    end
                end
                B_SQE: begin
                    r_sqe   <= w_sq;
                    r_state <= B_SQP;
                end
                B_SQP: begin
                    r_q     <= {1'b0, r_sqe} + {1'b0, w_sq};
                    r_state <= B_UPD;
                end
                B_UPD: begin
                    if (w_last) begin
                        r_state <= B_IDLE;
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= B_RD;
                    end
                end
                B_ERD: r_state <= B_ECMP;
                B_ECMP: begin
                    if (r_rd_sum > i_et_limit) begin
                        r_iso <= 1'b0;
                    end
                    if (w_last) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= B_ERD;
                    end
                end
                B_EMIT: begin
                    if (w_emit) begin
                        r_oiso  <= r_iso;
                        r_oovf  <= r_ovf;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ov;
    assign o_isolated     = r_oiso;
    assign o_ref_overflow = r_oovf;

    // a walk never visits an entry beyond the stored references
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD || r_state == B_ERD) |-> (CW'(r_j) < r_count))
        else $error("walk index beyond reference count");

    // the store never holds more references than it has entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REFS))
        else $error("reference count above store depth");

    // a new result starts a fresh event
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> (r_count == '0 && !r_ovf))
        else $error("event state not cleared at result");

endmodule

FILE: hdl/cone_isolation_energy_check_core.sv
// cone isolation energy check
// input channel: i_in_valid / o_in_stall with mode, px, py, pz and energy.
// mode 0 stores a reference, mode 1 adds a candidate's transverse energy
// to every reference cone it falls in, mode 2 closes the event and yields
// one result (o_isolated, o_ref_overflow) on o_out_valid / i_out_stall.
// configuration: i_cfg_we with i_cfg_index 0 cone radius, 1 et limit.
// a reference or candidate holds the input stalled while it is analyzed
// and until it is pushed into the queue: two 32-step bit-serial square
// roots (only the first with no transverse momentum), a 31-step divider,
// two passes of the shared log unit (normalize, then CORDIC_STEPS steps
// each) and CORDIC_STEPS rotation steps; an end of event holds it until pushed.
// the back walk visits each stored reference in turn: read, difference,
// two squares and update for a candidate, read and compare for an event end.
// a four-entry queue between the two lets the front analyze the next item
// while the back walks the store; the front takes one item at a time.
// reset empties the queue and store and loads the register defaults.
// a stalled result holds o_out_valid and its fields; the back waits with
// the next result until it is taken, and the queue then fills up.
module cone_isolation_energy_check_core #(
    parameter int MAX_REFS     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cie_pkg::t_mode      i_mode,
    input  logic signed [31:0]  i_px,
    input  logic signed [31:0]  i_py,
    input  logic signed [31:0]  i_pz,
    input  logic [30:0]         i_energy,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_isolated,
    output logic                o_ref_overflow,
    input  logic                i_cfg_we,
    input  cie_pkg::t_cfg_idx   i_cfg_index,
    input  logic [39:0]         i_cfg_data
);
    import cie_pkg::*;

    logic [15:0] r_cone_radius;
    logic [39:0] r_et_limit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cone_radius <= CONE_RADIUS_RESET;
            r_et_limit    <= ET_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONE_RADIUS: r_cone_radius <= i_cfg_data[15:0];
                CFG_ET_LIMIT:    r_et_limit    <= i_cfg_data;
                default:         r_et_limit    <= r_et_limit;
            endcase
        end
    end

    logic  w_push, w_full, w_pop, w_empty;
    t_item w_fitem, w_qitem;

    cie_front #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_mode   (i_mode),
        .i_px     (i_px),
        .i_py     (i_py),
        .i_pz     (i_pz),
        .i_energy (i_energy),
        .o_push   (w_push),
        .o_item   (w_fitem),
        .i_full   (w_full)
    );

    cie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_qitem),
        .o_empty (w_empty)
    );

    cie_back #(
        .MAX_REFS(MAX_REFS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_item         (w_qitem),
        .i_cone_radius  (r_cone_radius),
        .i_et_limit     (r_et_limit),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_isolated     (o_isolated),
        .o_ref_overflow (o_ref_overflow)
    );

endmodule

FILE: sim/cone_sum_checker.sv
module cone_sum_checker
    import cie_pkg::*;
#(
    parameter int MAX_REFS     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_mode              i_mode,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [30:0]        i_energy,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_isolated,
    input  logic               i_ref_overflow,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic [39:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] eta;
        logic signed [15:0] phi;
        bit                 flat;
        bit [39:0]          et;
    } t_track;

    typedef struct {
        bit iso;
        bit ovf;
    } t_verdict;

    // shadow of the block state
    logic signed [15:0] store_eta [MAX_REFS];
    logic signed [15:0] store_phi [MAX_REFS];
    bit                 store_flat [MAX_REFS];
    bit [39:0]          store_sum [MAX_REFS];
    int                 store_count;
    bit                 dropped_ref;
    bit [15:0]          radius;
    bit [39:0]          et_max;
    t_verdict           verdict_q [$];

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // natural log in Q.16 by shift-and-add over (1 + 2^-i)
    function automatic longint log_q16(bit [63:0] v);
        int        k;
        bit [63:0] m;
        bit [63:0] y;
        bit [63:0] t;
        longint    acc;
        if (v == 0) v = 1;
        k = 63;
        while (k > 0 && v[k] == 1'b0) k--;
        m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
        y = 64'd1 << 30;
        acc = 0;
        for (int i = 1; i <= CORDIC_STEPS; i++) begin
            t = y + (y >> i);
            if (t <= m) begin
                y = t;
                acc += longint'(LN1P_Q16[i - 1]);
            end
        end
        return longint'(k) * longint'(LN2_Q16) + acc;
    endfunction

    // vectoring rotation to get the azimuth, rounded to Q4.12
    function automatic logic signed [15:0] azimuth_q12(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(PIH_Q16);
            end else begin
                x = -y;
                y = t;
                z = -longint'(PIH_Q16);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q16[i]);
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q16[i]);
            end
        end
        z = (z + 8) >>> 4;
        return z[15:0];
    endfunction

    function automatic t_track classify(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz, logic [30:0] e);
        t_track    r;
        bit [63:0] ax;
        bit [63:0] ay;
        bit [63:0] az;
        bit [63:0] pt2;
        bit [63:0] pt;
        bit [63:0] pm;
        longint    eq;
        ax = (px < 0) ? 64'(-longint'(px)) : 64'(longint'(px));
        ay = (py < 0) ? 64'(-longint'(py)) : 64'(longint'(py));
        az = (pz < 0) ? 64'(-longint'(pz)) : 64'(longint'(pz));
        pt2 = ax * ax + ay * ay;
        pt = int_sqrt(pt2);
        r.flat = (pt == 0);
        r.eta = 0;
        r.phi = 0;
        r.et = 0;
        if (r.flat) return r;
        pm = int_sqrt(pt2 + az * az);
        r.et = 40'((64'(e) * pt) / pm);
        eq = log_q16(pm + az) - log_q16(pt);
        if (eq < 0) eq = 0;
        eq = (eq + 8) / 16;
        if (eq > 32767) eq = 32767;
        if (pz < 0) eq = -eq;
        r.eta = eq[15:0];
        r.phi = azimuth_q12(longint'(px), longint'(py));
        return r;
    endfunction

    function automatic bit within_cone(logic signed [15:0] ea, logic signed [15:0] pa,
                                       logic signed [15:0] eb, logic signed [15:0] pb);
        longint deta;
        longint dphi;
        deta = longint'(ea) - longint'(eb);
        dphi = longint'(pa) - longint'(pb);
        if (dphi < 0) dphi = -dphi;
        if (dphi > longint'(PI_Q12)) dphi = longint'(TWO_PI_Q12) - dphi;
        if (dphi < 0) dphi = -dphi;
        return (deta * deta + dphi * dphi) < longint'(radius) * longint'(radius);
    endfunction

    always @(posedge i_clk) begin
        t_track   trk;
        t_verdict v;
        bit [40:0] acc;
        int       nerr;
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_REFS; j++) store_sum[j] = 0;
            store_count = 0;
            dropped_ref = 0;
            radius = CONE_RADIUS_RESET;
            et_max = ET_LIMIT_RESET;
            verdict_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            nerr = 0;
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CONE_RADIUS) radius = i_cfg_data[15:0];
                else if (i_cfg_index == CFG_ET_LIMIT) et_max = i_cfg_data;
            end

            // compare a delivered result with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result with nothing expected: isolated %0b ref_overflow %0b",
                           i_isolated, i_ref_overflow);
                    nerr++;
                end else begin
                    v = verdict_q.pop_front();
                    if (i_isolated !== v.iso) begin
                        $error("isolated: expected %0b actual %0b", v.iso, i_isolated);
                        nerr++;
                    end
                    if (i_ref_overflow !== v.ovf) begin
                        $error("ref_overflow: expected %0b actual %0b", v.ovf, i_ref_overflow);
                        nerr++;
                    end
                end
            end

            // accepted request updates the prediction
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    MODE_REF: begin
                        if (store_count < MAX_REFS) begin
                            trk = classify(i_px, i_py, i_pz, i_energy);
                            store_eta[store_count] = trk.eta;
                            store_phi[store_count] = trk.phi;
                            store_flat[store_count] = trk.flat;
                            store_sum[store_count] = 0;
                            store_count++;
                        end else begin
                            dropped_ref = 1;
                        end
                    end
                    MODE_CAND: begin
                        trk = classify(i_px, i_py, i_pz, i_energy);
                        if (!trk.flat) begin
                            for (int j = 0; j < store_count; j++) begin
                                if (!store_flat[j] &&
                                    within_cone(store_eta[j], store_phi[j], trk.eta, trk.phi)) begin
                                    acc = {1'b0, store_sum[j]} + {1'b0, trk.et};
                                    store_sum[j] = acc[40] ? SUM_MAX : acc[39:0];
                                end
                            end
                        end
                    end
                    MODE_END: begin
                        v.iso = 1;
                        for (int j = 0; j < store_count; j++)
                            if (store_sum[j] > et_max) v.iso = 0;
                        v.ovf = dropped_ref;
                        verdict_q.push_back(v);
                        for (int j = 0; j < MAX_REFS; j++) store_sum[j] = 0;
                        store_count = 0;
                        dropped_ref = 0;
                    end
                    default: ;
                endcase
            end
            o_errors <= o_errors + nerr;
            o_pending <= verdict_q.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import cie_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;
    localparam int SETTLE     = 600;
    localparam int HOLD_LEN   = 8000;
    localparam int ITEM_GOAL  = 1700;
    localparam int SAT_LEN    = 520;
    localparam t_mode MODE_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_mode              i_mode;
    logic signed [31:0] i_px;
    logic signed [31:0] i_py;
    logic signed [31:0] i_pz;
    logic [30:0]        i_energy;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_isolated;
    logic               o_ref_overflow;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_index;
    logic [39:0]        i_cfg_data;
    int                 errors;
    int                 pending;

    bit quiet;
    bit hold_req;
    bit hold_done;
    int n_items;
    int n_events;
    int n_refs;
    int n_cands;
    int idle_cycles;
    logic signed [31:0] ref_x [$];
    logic signed [31:0] ref_y [$];
    logic signed [31:0] ref_z [$];

    cone_isolation_energy_check_core i_dut (.*);

    cone_sum_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_px           (i_px),
        .i_py           (i_py),
        .i_pz           (i_pz),
        .i_energy       (i_energy),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_isolated     (o_isolated),
        .i_ref_overflow (o_ref_overflow),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1;
            end else begin
                i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 37);
            end
        end
    end

    task automatic send(t_mode m, logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [31:0] z, logic [30:0] e);
        if (!quiet && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_px <= x;
        i_py <= y;
        i_pz <= z;
        i_energy <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_items++;
        if (m == MODE_REF) begin
            n_refs++;
            ref_x.push_back(x);
            ref_y.push_back(y);
            ref_z.push_back(z);
        end
        if (m == MODE_CAND) n_cands++;
        if (m == MODE_END) begin
            n_events++;
            ref_x.delete();
            ref_y.delete();
            ref_z.delete();
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [39:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(2))
            0: return int'($urandom_range(2000)) - 1000;
            1: return int'($urandom_range(1 << 21)) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_energy();
        return ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(50000));
    endfunction

    // random particle, or one close to a stored reference
    task automatic send_particle(t_mode m);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        int k;
        if (m == MODE_CAND && ref_x.size() > 0 && $urandom_range(99) < 60) begin
            k = $urandom_range(ref_x.size() - 1);
            x = clip32(longint'(ref_x[k]) + (longint'(ref_x[k]) >>> 6) *
                       (int'($urandom_range(4)) - 2) + int'($urandom_range(6)) - 3);
            y = clip32(longint'(ref_y[k]) + (longint'(ref_y[k]) >>> 6) *
                       (int'($urandom_range(4)) - 2) + int'($urandom_range(6)) - 3);
            z = clip32(longint'(ref_z[k]) + (longint'(ref_z[k]) >>> 6) *
                       (int'($urandom_range(4)) - 2));
        end else begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if ($urandom_range(99) < 5) begin
                x = 0;
                y = 0;
            end
        end
        send(m, x, y, z, rand_energy());
    endtask

    task automatic random_event();
        int nr;
        int nc;
        if ($urandom_range(99) < 10) begin
            // noise: any mode in any order, including the unused code
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(3))
                    0: send_particle(MODE_REF);
                    1: send_particle(MODE_CAND);
                    2: send(MODE_END, rand_comp(), rand_comp(), rand_comp(), rand_energy());
                    default: send(MODE_UNUSED, rand_comp(), rand_comp(), rand_comp(),
                                  rand_energy());
                endcase
            end
            return;
        end
        nr = ($urandom_range(99) < 6) ? $urandom_range(16, 18) : $urandom_range(0, 5);
        nc = $urandom_range(0, 8);
        repeat (nr) send_particle(MODE_REF);
        repeat (nc) send_particle(MODE_CAND);
        // an occasional late reference
        if ($urandom_range(99) < 10) begin
            send_particle(MODE_REF);
            send_particle(MODE_CAND);
        end
        send(MODE_END, $urandom, $urandom, $urandom, 31'($urandom));
    endtask

    initial begin
        logic [15:0] radii [5];
        logic [39:0] limits [5];
        int goal;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_REF;
        i_px = 0;
        i_py = 0;
        i_pz = 0;
        i_energy = 0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_CONE_RADIUS;
        i_cfg_data = 0;
        quiet = 0;
        hold_req = 0;
        n_items = 0;
        n_events = 0;
        n_refs = 0;
        n_cands = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, flat particles, unused code, late reference
        send(MODE_END, 0, 0, 0, 0);
        send(MODE_REF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
        send(MODE_REF, 0, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send(MODE_REF, 32'sh7FFF_FFFF, 0, 0, 0);
        send(MODE_CAND, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
        send(MODE_CAND, 0, 0, 32'sh8000_0000, 31'h7FFF_FFFF);
        send(MODE_CAND, 32'sh7FFF_FFFF, 1, 0, 31'h7FFF_FFFF);
        send(MODE_CAND, 32'sh7FFF_FFFF, -1, 5, 12345);
        send(MODE_UNUSED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        send(MODE_END, -1, -1, -1, 31'h7FFF_FFFF);
        send(MODE_REF, -1000, -1, 300, 7);
        send(MODE_CAND, -1000, 1, 300, 9000);
        send(MODE_REF, -1000, 0, 310, 0);
        send(MODE_CAND, -1001, -2, 299, 9000);
        send(MODE_CAND, 1, 1000, -20, 31'h7FFF_FFFF);
        send(MODE_END, 0, 0, 0, 0);
        drain();

        radii = '{CONE_RADIUS_RESET, 16'd0, 16'hFFFF, 16'd4000, 16'd800};
        limits = '{ET_LIMIT_RESET, 40'd0, SUM_MAX, 40'd1 << 20, 40'($urandom) << 4};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_CONE_RADIUS, 40'(radii[ph]));
            write_reg(CFG_ET_LIMIT, limits[ph]);
            quiet = (ph == 1);
            if (ph == 3) hold_req = 1;
            goal = n_items + (ITEM_GOAL - 16 - (SAT_LEN + 2)) / 5;
            while (n_items < goal) random_event();
            drain();
        end

        // saturate one cone sum just beyond the limit
        write_reg(CFG_CONE_RADIUS, 40'd2000);
        write_reg(CFG_ET_LIMIT, SUM_MAX - 1);
        quiet = 1;
        send(MODE_REF, 1000000, 0, 0, 0);
        repeat (SAT_LEN) send(MODE_CAND, 1000000, 0, 0, 31'h7FFF_FFFF);
        send(MODE_END, 0, 0, 0, 0);
        drain();

        $display("covered %0d requests: %0d events, %0d references, %0d candidates",
                 n_items, n_events, n_refs, n_cands);
        $display("five cone/limit settings incl. extremes, long output hold-off, saturation");
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

FILE: cone_isolation_energy_check_core.f
hdl/cie_pkg.sv
hdl/cie_front.sv
hdl/cie_queue.sv
hdl/cie_back.sv
hdl/cone_isolation_energy_check_core.sv
sim/cone_sum_checker.sv
sim/tb_top.sv
